// ===== hdl/spi_pkg.sv =====
package spi_pkg;

  typedef enum logic [1:0] {
    HIT_NONE    = 2'd0,
    HIT_POINT   = 2'd1,
    HIT_SEGMENT = 2'd2
  } hit_kind_e;

endpackage

// ===== hdl/spi_place.sv =====
// trunc toward zero of base + delta * num / den, with 0 <= num <= den, den > 0
module spi_place #(
  parameter int CoordBits = 24
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [CoordBits-1:0] base_i,
  input  logic signed [CoordBits:0]   delta_i,
  input  logic [2*CoordBits+1:0]      num_i,
  input  logic [2*CoordBits+1:0]      den_i,
  output logic signed [CoordBits-1:0] res_o
);

  localparam int MW = CoordBits + 1;      // magnitude of delta, also quotient bits
  localparam int NW = 2 * CoordBits + 2;  // num / den width
  localparam int PW = 3 * CoordBits + 3;  // product width

  // multiply stage, split into two half-width partial products
  logic [MW-1:0] mag;
  logic [NW-1:0] pl_q, ph_q, pl_d, ph_d;
  logic [NW-1:0] den_a_q;
  logic signed [CoordBits-1:0] base_a_q;
  logic neg_a_q;

  always_comb begin
    mag  = delta_i[CoordBits] ? MW'(-delta_i) : MW'(delta_i);
    pl_d = NW'(mag) * NW'(num_i[MW-1:0]);
    ph_d = NW'(mag) * NW'(num_i[NW-1:MW]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q     <= pl_d;
      ph_q     <= ph_d;
      den_a_q  <= den_i;
      base_a_q <= base_i;
      neg_a_q  <= delta_i[CoordBits];
    end
  end

  // sum stage, loads the divider
  logic [PW-1:0] prod;
  assign prod = {ph_q, {MW{1'b0}}} + PW'(pl_q);

  logic [NW-1:0] r_q    [MW+1];
  logic [MW-1:0] low_q  [MW+1];
  logic [MW-1:0] quo_q  [MW+1];
  logic [NW-1:0] den_q  [MW+1];
  logic signed [CoordBits-1:0] base_q [MW+1];
  logic          neg_q  [MW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= prod[PW-1:MW];
      low_q[0]  <= prod[MW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_a_q;
      base_q[0] <= base_a_q;
      neg_q[0]  <= neg_a_q;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < MW; i++) begin : g_div
    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;
    assign trial = {r_q[i], low_q[i][MW-1]};
    assign ge    = trial >= {1'b0, den_q[i]};
    assign diff  = trial - {1'b0, den_q[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i+1]    <= ge ? diff[NW-1:0] : trial[NW-1:0];
        low_q[i+1]  <= {low_q[i][MW-2:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][MW-2:0], ge};
        den_q[i+1]  <= den_q[i];
        base_q[i+1] <= base_q[i];
        neg_q[i+1]  <= neg_q[i];
      end
    end
  end

  // apply quotient, round toward zero when inexact
  logic signed [CoordBits+1:0] bx, qx, sum;
  logic signed [CoordBits-1:0] res_d, res_q;

  always_comb begin
    bx  = (CoordBits+2)'(base_q[MW]);
    qx  = signed'({1'b0, quo_q[MW]});
    sum = neg_q[MW] ? bx - qx : bx + qx;
    if (r_q[MW] != '0) begin
      if (!neg_q[MW] && sum < 0) begin
        sum = sum + (CoordBits+2)'(1);
      end else if (neg_q[MW] && sum > 0) begin
        sum = sum - (CoordBits+2)'(1);
      end
    end
    res_d = sum[CoordBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/segment_pair_intersect_2d.sv =====
// Classifies the intersection of two 2D segments given as four endpoints in signed
// fixed point (Q16.8 at the default width): disjoint, one point, or a collinear overlap
// with two points. Cross products are exact; reported coordinates are the exact rational
// points truncated toward zero. Fully pipelined: one pair per cycle, with a restoring
// divider that resolves one quotient bit per stage. A stall on the output holds the whole
// pipeline.
module segment_pair_intersect_2d #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   hit_kind_o,
  output logic signed [COORD_BITS-1:0] first_x_o,
  output logic signed [COORD_BITS-1:0] first_y_o,
  output logic signed [COORD_BITS-1:0] second_x_o,
  output logic signed [COORD_BITS-1:0] second_y_o
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;        // coordinate differences
  localparam int PW  = 2 * CW + 2;    // single products
  localparam int XW  = 2 * CW + 3;    // cross products
  localparam int NW  = 2 * CW + 2;    // divider num / den
  localparam int LAT = CW + 4;        // latency of spi_place

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: differences
  logic v1_q;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q, zx_q, zy_q;
  logic signed [CW-1:0] p1x_1_q, p1y_1_q, p3x_1_q, p3y_1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q    <= DW'(a_end_x_i) - DW'(a_start_x_i);
      uy_q    <= DW'(a_end_y_i) - DW'(a_start_y_i);
      vx_q    <= DW'(b_end_x_i) - DW'(b_start_x_i);
      vy_q    <= DW'(b_end_y_i) - DW'(b_start_y_i);
      wx_q    <= DW'(a_start_x_i) - DW'(b_start_x_i);
      wy_q    <= DW'(a_start_y_i) - DW'(b_start_y_i);
      zx_q    <= DW'(a_end_x_i) - DW'(b_start_x_i);
      zy_q    <= DW'(a_end_y_i) - DW'(b_start_y_i);
      p1x_1_q <= a_start_x_i;
      p1y_1_q <= a_start_y_i;
      p3x_1_q <= b_start_x_i;
      p3y_1_q <= b_start_y_i;
    end
  end

  // stage 2: products
  logic v2_q;
  logic signed [PW-1:0] m_uxvy_q, m_uyvx_q, m_vxwy_q, m_vywx_q, m_uxwy_q, m_uywx_q;
  logic signed [DW-1:0] ux2_q, uy2_q, vx2_q, vy2_q, wx2_q, wy2_q, zx2_q, zy2_q;
  logic signed [CW-1:0] p1x_2_q, p1y_2_q, p3x_2_q, p3y_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_uxvy_q <= PW'(ux_q) * PW'(vy_q);
      m_uyvx_q <= PW'(uy_q) * PW'(vx_q);
      m_vxwy_q <= PW'(vx_q) * PW'(wy_q);
      m_vywx_q <= PW'(vy_q) * PW'(wx_q);
      m_uxwy_q <= PW'(ux_q) * PW'(wy_q);
      m_uywx_q <= PW'(uy_q) * PW'(wx_q);
      ux2_q    <= ux_q;
      uy2_q    <= uy_q;
      vx2_q    <= vx_q;
      vy2_q    <= vy_q;
      wx2_q    <= wx_q;
      wy2_q    <= wy_q;
      zx2_q    <= zx_q;
      zy2_q    <= zy_q;
      p1x_2_q  <= p1x_1_q;
      p1y_2_q  <= p1y_1_q;
      p3x_2_q  <= p3x_1_q;
      p3y_2_q  <= p3y_1_q;
    end
  end

  // stage 3: cross products
  logic v3_q;
  logic signed [XW-1:0] d_q, cvw_q, cuw_q;
  logic signed [DW-1:0] ux3_q, uy3_q, vx3_q, vy3_q, wx3_q, wy3_q, zx3_q, zy3_q;
  logic signed [CW-1:0] p1x_3_q, p1y_3_q, p3x_3_q, p3y_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q     <= XW'(m_uxvy_q) - XW'(m_uyvx_q);
      cvw_q   <= XW'(m_vxwy_q) - XW'(m_vywx_q);
      cuw_q   <= XW'(m_uxwy_q) - XW'(m_uywx_q);
      ux3_q   <= ux2_q;
      uy3_q   <= uy2_q;
      vx3_q   <= vx2_q;
      vy3_q   <= vy2_q;
      wx3_q   <= wx2_q;
      wy3_q   <= wy2_q;
      zx3_q   <= zx2_q;
      zy3_q   <= zy2_q;
      p1x_3_q <= p1x_2_q;
      p1y_3_q <= p1y_2_q;
      p3x_3_q <= p3x_2_q;
      p3y_3_q <= p3y_2_q;
    end
  end

  // stage 4: classify and set up the four coordinate divisions
  spi_pkg::hit_kind_e kind_d;
  logic signed [CW-1:0] fbx_d, fby_d, sbx_d, sby_d;
  logic signed [DW-1:0] fdx_d, fdy_d, sdx_d, sdy_d;
  logic [NW-1:0] fnum_d, snum_d, den_d;

  logic upt, vpt, sel, in_seg;
  logic signed [DW-1:0]   wa, vc;
  logic signed [DW:0]     na, nc, dd, a0, a1, tmp;
  logic signed [XW-1:0]   ad, ns, nt;

  always_comb begin
    kind_d = spi_pkg::HIT_NONE;
    fbx_d  = '0;
    fby_d  = '0;
    sbx_d  = '0;
    sby_d  = '0;
    fdx_d  = '0;
    fdy_d  = '0;
    sdx_d  = '0;
    sdy_d  = '0;
    fnum_d = '0;
    snum_d = '0;
    den_d  = NW'(1);
    upt    = (ux3_q == '0) && (uy3_q == '0);
    vpt    = (vx3_q == '0) && (vy3_q == '0);
    sel    = (vx3_q != '0);
    wa     = sel ? wx3_q : wy3_q;
    vc     = sel ? vx3_q : vy3_q;
    na     = -(DW+1)'(ux3_q != '0 ? wx3_q : wy3_q);
    nc     = (DW+1)'(ux3_q != '0 ? ux3_q : uy3_q);
    in_seg = 1'b0;
    dd     = (DW+1)'(vc);
    a0     = (DW+1)'(wa);
    a1     = (DW+1)'(sel ? zx3_q : zy3_q);
    tmp    = '0;
    ad     = d_q[XW-1] ? -d_q : d_q;
    ns     = d_q[XW-1] ? -cvw_q : cvw_q;
    nt     = d_q[XW-1] ? -cuw_q : cuw_q;

    if (d_q == '0) begin
      if (cuw_q != '0 || cvw_q != '0) begin
        kind_d = spi_pkg::HIT_NONE;
      end else if (upt && vpt) begin
        if (wx3_q == '0 && wy3_q == '0) begin
          kind_d = spi_pkg::HIT_POINT;
          fbx_d  = p1x_3_q;
          fby_d  = p1y_3_q;
        end
      end else if (upt) begin
        in_seg = (wa >= 0 && wa <= vc) || (wa <= 0 && wa >= vc);
        if (in_seg) begin
          kind_d = spi_pkg::HIT_POINT;
          fbx_d  = p1x_3_q;
          fby_d  = p1y_3_q;
        end
      end else if (vpt) begin
        in_seg = (na >= 0 && na <= nc) || (na <= 0 && na >= nc);
        if (in_seg) begin
          kind_d = spi_pkg::HIT_POINT;
          fbx_d  = p3x_3_q;
          fby_d  = p3y_3_q;
        end
      end else begin
        // collinear: parameters of a's endpoints along b
        if (dd < 0) begin
          dd = -dd;
          a0 = -a0;
          a1 = -a1;
        end
        if (a0 > a1) begin
          tmp = a0;
          a0  = a1;
          a1  = tmp;
        end
        if (!(a0 > dd || a1 < 0)) begin
          if (a0 < 0) begin
            a0 = '0;
          end
          if (a1 > dd) begin
            a1 = dd;
          end
          den_d  = NW'($unsigned(dd));
          fbx_d  = p3x_3_q;
          fby_d  = p3y_3_q;
          fdx_d  = vx3_q;
          fdy_d  = vy3_q;
          fnum_d = NW'($unsigned(a0));
          if (a0 == a1) begin
            kind_d = spi_pkg::HIT_POINT;
          end else begin
            kind_d = spi_pkg::HIT_SEGMENT;
            sbx_d  = p3x_3_q;
            sby_d  = p3y_3_q;
            sdx_d  = vx3_q;
            sdy_d  = vy3_q;
            snum_d = NW'($unsigned(a1));
          end
        end
      end
    end else begin
      if (ns >= 0 && ns <= ad && nt >= 0 && nt <= ad) begin
        kind_d = spi_pkg::HIT_POINT;
        den_d  = ad[NW-1:0];
        fbx_d  = p1x_3_q;
        fby_d  = p1y_3_q;
        fdx_d  = ux3_q;
        fdy_d  = uy3_q;
        fnum_d = ns[NW-1:0];
      end
    end
  end

  logic v4_q;
  spi_pkg::hit_kind_e kind4_q;
  logic signed [CW-1:0] fbx_q, fby_q, sbx_q, sby_q;
  logic signed [DW-1:0] fdx_q, fdy_q, sdx_q, sdy_q;
  logic [NW-1:0] fnum_q, snum_q, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind4_q <= kind_d;
      fbx_q   <= fbx_d;
      fby_q   <= fby_d;
      sbx_q   <= sbx_d;
      sby_q   <= sby_d;
      fdx_q   <= fdx_d;
      fdy_q   <= fdy_d;
      sdx_q   <= sdx_d;
      sdy_q   <= sdy_d;
      fnum_q  <= fnum_d;
      snum_q  <= snum_d;
      den_q   <= den_d;
    end
  end

  // coordinate units
  spi_place #(.CoordBits(CW)) u_first_x (
    .clk_i, .en_i(en), .base_i(fbx_q), .delta_i(fdx_q),
    .num_i(fnum_q), .den_i(den_q), .res_o(first_x_o)
  );
  spi_place #(.CoordBits(CW)) u_first_y (
    .clk_i, .en_i(en), .base_i(fby_q), .delta_i(fdy_q),
    .num_i(fnum_q), .den_i(den_q), .res_o(first_y_o)
  );
  spi_place #(.CoordBits(CW)) u_second_x (
    .clk_i, .en_i(en), .base_i(sbx_q), .delta_i(sdx_q),
    .num_i(snum_q), .den_i(den_q), .res_o(second_x_o)
  );
  spi_place #(.CoordBits(CW)) u_second_y (
    .clk_i, .en_i(en), .base_i(sby_q), .delta_i(sdy_q),
    .num_i(snum_q), .den_i(den_q), .res_o(second_y_o)
  );

  // kind and valid ride alongside the coordinate units
  logic               vld_q  [LAT];
  spi_pkg::hit_kind_e kind_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q[0] <= kind4_q;
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        kind_q[k] <= kind_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign hit_kind_o  = kind_q[LAT-1];

endmodule
